// File: hdl/epd_waveform_source_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// EPD waveform source mapper assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef EPD_WAVEFORM_SOURCE_MAPPER_CORE_ASSERT_SVH
`define EPD_WAVEFORM_SOURCE_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EPDWSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication
`define EPDWSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define EPDWSM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EPDWSM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/epdwsm_pkg.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper package
// Register map, field widths, reset values and the front-to-back job type.
// ----------------------------------------------------------------------------
package epdwsm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int WAVE_W      = 64;
  localparam int BPR_W       = 8;
  localparam int RPF_W       = 12;
  localparam int FPU_W       = 6;
  localparam int PIX_W       = 8;
  localparam int CODE_W      = 2;
  localparam int SLOTS       = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SET   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_CLEAR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BPR        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RPF        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FPU        = 3'd4;

  localparam logic [BPR_W-1:0] BPR_RESET = 8'd181;
  localparam logic [RPF_W-1:0] RPF_RESET = 12'd1073;
  localparam logic [FPU_W-1:0] FPU_RESET = 6'd32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified image byte, waiting for the back end
  typedef struct packed {
    logic [PIX_W-1:0]  image_byte;
    logic [CODE_W-1:0] code_set;
    logic [CODE_W-1:0] code_clear;
    logic              row_first;
    logic              row_last;
    logic              frame_last;
    logic              update_last;
  } job_t;

endpackage

// File: hdl/epdwsm_img_if.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper image channel
// Valid/ready channel carrying one byte of eight 1-bit pixels.
// ----------------------------------------------------------------------------
interface epdwsm_img_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink   (input valid, input image_byte, output ready);
endinterface

// File: hdl/epdwsm_src_if.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper source-driver channel
// Valid/ready channel carrying one source byte and its position marks.
// ----------------------------------------------------------------------------
interface epdwsm_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       row_first;
  logic       row_last;
  logic       frame_last;
  logic       update_last;
  logic       last_of_pair;

  modport source (output valid, output source_byte, output row_first, output row_last,
                  output frame_last, output update_last, output last_of_pair,
                  input ready);
  modport sink   (input valid, input source_byte, input row_first, input row_last,
                  input frame_last, input update_last, input last_of_pair,
                  output ready);
endinterface

// File: hdl/epdwsm_queue.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper job queue
// Two-entry first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module epdwsm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  epdwsm_pkg::job_t   push_job,
  output logic               head_valid,
  input  logic               pop,
  output epdwsm_pkg::job_t   head_job
);
  import epdwsm_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/epdwsm_front.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper front end
// Holds the registers and position counters, classifies each image byte
// and picks the current frame's drive codes for the job queue.
// ----------------------------------------------------------------------------
module epdwsm_front #(
  parameter int MAX_FRAMES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [epdwsm_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [epdwsm_pkg::CFG_DATA_W-1:0]   wr_data,
  epdwsm_img_if.sink                          img,
  output logic                                push_valid,
  input  logic                                push_ready,
  output epdwsm_pkg::job_t                    push_job
);
  import epdwsm_pkg::*;

  localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [WAVE_W-1:0]  wave_for_set;
  logic [WAVE_W-1:0]  wave_for_clear;
  logic [BPR_W-1:0]   bytes_per_row;
  logic [RPF_W-1:0]   rows_per_frame;
  logic [FPU_W-1:0]   frames_per_update;

  logic [BPR_W-1:0]   byte_position;
  logic [RPF_W-1:0]   row_count;
  logic [FRAME_W-1:0] frame_count;

  logic [BPR_W-1:0]   bpr_eff;
  logic [RPF_W-1:0]   rpf_eff;
  logic [FPU_W-1:0]   fpu_eff;
  logic               rlast;
  logic               flast;
  logic               ulast;
  logic [5:0]         code_sel;
  logic               accept;

  // a zero count acts as one; too many frames clamps to the frame capacity
  assign bpr_eff = (bytes_per_row == '0) ? BPR_W'(1) : bytes_per_row;
  assign rpf_eff = (rows_per_frame == '0) ? RPF_W'(1) : rows_per_frame;
  always_comb begin
    if (frames_per_update == '0) begin
      fpu_eff = FPU_W'(1);
    end else if (frames_per_update > FPU_W'(MAX_FRAMES)) begin
      fpu_eff = FPU_W'(MAX_FRAMES);
    end else begin
      fpu_eff = frames_per_update;
    end
  end

  // a counter at or past its limit counts as last
  assign rlast = ({1'b0, byte_position} + 9'd1) >= {1'b0, bpr_eff};
  assign flast = rlast && (({1'b0, row_count} + 13'd1) >= {1'b0, rpf_eff});
  assign ulast = flast && ((7'(frame_count) + 7'd1) >= {1'b0, fpu_eff});

  assign code_sel = {5'(frame_count), 1'b0};

  assign push_valid = img.valid;
  assign img.ready  = push_ready;
  assign accept     = img.valid & push_ready;

  always_comb begin
    push_job.image_byte  = img.image_byte;
    push_job.code_set    = wave_for_set[code_sel +: CODE_W];
    push_job.code_clear  = wave_for_clear[code_sel +: CODE_W];
    push_job.row_first   = (byte_position == '0);
    push_job.row_last    = rlast;
    push_job.frame_last  = flast;
    push_job.update_last = ulast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_for_set      <= '0;
      wave_for_clear    <= '0;
      bytes_per_row     <= BPR_RESET;
      rows_per_frame    <= RPF_RESET;
      frames_per_update <= FPU_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_WAVE_SET:   wave_for_set      <= wr_data[WAVE_W-1:0];
        REG_WAVE_CLEAR: wave_for_clear    <= wr_data[WAVE_W-1:0];
        REG_BPR:        bytes_per_row     <= wr_data[BPR_W-1:0];
        REG_RPF:        rows_per_frame    <= wr_data[RPF_W-1:0];
        REG_FPU:        frames_per_update <= wr_data[FPU_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_count     <= '0;
      frame_count   <= '0;
    end else if (accept) begin
      if (!rlast) begin
        byte_position <= byte_position + BPR_W'(1);
      end else begin
        byte_position <= '0;
        if (!flast) begin
          row_count <= row_count + RPF_W'(1);
        end else begin
          row_count <= '0;
          // wrap at end of update
          if (!ulast) begin
            frame_count <= frame_count + FRAME_W'(1);
          end else begin
            frame_count <= '0;
          end
        end
      end
    end
  end

endmodule

// File: hdl/epdwsm_back.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper back end
// Expands each queued job into two source bytes, high nibble first,
// through a registered output stage.
// ----------------------------------------------------------------------------
module epdwsm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  epdwsm_pkg::job_t   head_job,
  output logic               pop,
  epdwsm_src_if.source       src
);
  import epdwsm_pkg::*;

  logic               second;
  logic               load;
  logic [SLOTS-1:0]   nibble;
  logic [PIX_W-1:0]   mapped;
  logic               out_valid;
  logic [PIX_W-1:0]   out_byte;
  logic               out_row_first;
  logic               out_row_last;
  logic               out_frame_last;
  logic               out_update_last;
  logic               out_last_of_pair;

  assign load   = !out_valid || src.ready;
  assign pop    = load && head_valid && second;
  assign nibble = second ? head_job.image_byte[SLOTS-1:0]
                         : head_job.image_byte[PIX_W-1:SLOTS];

  always_comb begin
    mapped = '0;
    for (int k = 0; k < SLOTS; k++) begin
      mapped[CODE_W*k +: CODE_W] = nibble[k] ? head_job.code_set : head_job.code_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        second <= !second;
      end
    end
    // payload holds while stalled
    if (load && head_valid) begin
      out_byte         <= mapped;
      out_row_first    <= !second && head_job.row_first;
      out_row_last     <= second && head_job.row_last;
      out_frame_last   <= second && head_job.frame_last;
      out_update_last  <= second && head_job.update_last;
      out_last_of_pair <= second;
    end
  end

  assign src.valid        = out_valid;
  assign src.source_byte  = out_byte;
  assign src.row_first    = out_row_first;
  assign src.row_last     = out_row_last;
  assign src.frame_last   = out_frame_last;
  assign src.update_last  = out_update_last;
  assign src.last_of_pair = out_last_of_pair;

endmodule

// File: hdl/epd_waveform_source_mapper_core.sv
// ----------------------------------------------------------------------------
// EPD waveform source mapper core
// Maps 1-bit-per-pixel image bytes to e-paper source-driver bytes.
// ----------------------------------------------------------------------------
// Each accepted image byte yields two source bytes (image bits 7..4 first,
// then 3..0), each holding four 2-bit drive codes taken from the current
// frame of the set or clear waveform, with row, frame and update end marks.
// The output register sends one source byte per cycle while the source side
// is ready. Each accepted image byte is registered in the job queue, then
// its first source byte is loaded into the output register and presented,
// and the second byte follows on the next cycle once the first transfers.
// A two-entry job queue lets the input side accept up to two image bytes
// while the output is stalled. Write registers only while idle.
module epd_waveform_source_mapper_core #(
  parameter int MAX_FRAMES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [epdwsm_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [epdwsm_pkg::CFG_DATA_W-1:0]   wr_data,
  epdwsm_img_if.sink                          img,
  epdwsm_src_if.source                        src
);
  import epdwsm_pkg::*;

`include "epd_waveform_source_mapper_core_assert.svh"

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic head_valid;
  logic pop;
  job_t head_job;

  epdwsm_front #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .img        (img),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  epdwsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  epdwsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .src        (src)
  );

  // first half of a pair is always followed at once by its second half
  `EPDWSM_ASSERT_NEXT(a_pair_follows, clk, rst, src.valid && src.ready && !src.last_of_pair, src.valid && src.last_of_pair)
  // end marks ride only on the second half
  `EPDWSM_ASSERT_IMPL(a_marks_on_second, clk, rst, src.valid && (src.row_last || src.frame_last), src.last_of_pair)
  // update end implies frame and row end
  `EPDWSM_ASSERT_IMPL(a_update_nested, clk, rst, src.valid && src.update_last, src.frame_last && src.row_last)

endmodule
